[rtl/fursq_pkg.sv]
// ----------------------------------------------------------------------------
// fursq_pkg: shared types and constants for the unary rounding and root unit
// Holds the operation codes, the pipeline word carried between cells and the
// stage count of the square-root cell chain.
// ----------------------------------------------------------------------------
package fursq_pkg;

    // Operation codes.
    localparam logic [2:0] MODE_ABS     = 3'd0;
    localparam logic [2:0] MODE_NEG     = 3'd1;
    localparam logic [2:0] MODE_CEIL    = 3'd2;
    localparam logic [2:0] MODE_FLOOR   = 3'd3;
    localparam logic [2:0] MODE_TRUNC   = 3'd4;
    localparam logic [2:0] MODE_NEAREST = 3'd5;
    localparam logic [2:0] MODE_SQRT    = 3'd6;

    // One root bit per cell: 54 root bits for binary64 (mb + 2).
    localparam int NCELL = 54;
    // Radicand width: 2 * NCELL bits.
    localparam int RW = 2 * NCELL;
    // Remainder width: root bits + 2.
    localparam int REMW = NCELL + 2;

    // Word handed from cell to cell.
    typedef struct packed {
        logic            vld;
        logic            bypass;     // result already known, root not used
        logic [63:0]     res;        // bypass result
        logic            dbl;
        logic [11:0]     rexp;       // biased result exponent
        logic [RW-1:0]   rad;        // radicand, consumed two bits a cell
        logic [REMW-1:0] rem;        // partial remainder
        logic [NCELL-1:0] q;         // partial root
    } cell_word_t;

endpackage

[rtl/fursq_cell.sv]
// ----------------------------------------------------------------------------
// fursq_cell: one restoring square-root step
// Takes the next two radicand bits, forms one root bit and registers the
// word for the next cell.
// ----------------------------------------------------------------------------
module fursq_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  fursq_pkg::cell_word_t  din,
    output fursq_pkg::cell_word_t  dout
);

    fursq_pkg::cell_word_t word_reg;
    fursq_pkg::cell_word_t word_next;
    logic [fursq_pkg::REMW-1:0] rem_sh;
    logic [fursq_pkg::REMW-1:0] trial;

    // Shift in a bit pair and try subtracting 4q+1.
    always_comb
    begin
        word_next = din;
        rem_sh = {din.rem[fursq_pkg::REMW-3:0], din.rad[fursq_pkg::RW-1 -: 2]};
        trial = {din.q, 2'b01};
        word_next.rad = {din.rad[fursq_pkg::RW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            word_next.rem = rem_sh - trial;
            word_next.q = {din.q[fursq_pkg::NCELL-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = rem_sh;
            word_next.q = {din.q[fursq_pkg::NCELL-2:0], 1'b0};
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

[rtl/fursq_front.sv]
// ----------------------------------------------------------------------------
// fursq_front: operand decode, sign and rounding operations, root set-up
// Works out every non-root result directly and prepares the normalised,
// aligned radicand and the result exponent for the square-root chain.
// ----------------------------------------------------------------------------
module fursq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [2:0]            mode,
    input  logic                  is_double,
    input  logic [63:0]           operand_bits,
    output fursq_pkg::cell_word_t dout
);

    fursq_pkg::cell_word_t word_reg;
    fursq_pkg::cell_word_t word_next;

    logic [63:0] x;
    logic [63:0] signbit;
    logic [63:0] qbit;
    logic        neg;
    logic [10:0] e;
    logic [10:0] emask;
    logic [10:0] bias;
    logic [51:0] mant;
    logic [63:0] one;
    logic [63:0] sgn;
    logic [63:0] rnd;
    logic [11:0] fcnt;
    logic [63:0] fmask;
    logic [63:0] frac;
    logic [63:0] base;
    logic [63:0] half;
    logic [63:0] fstep;
    logic        inc;
    logic [52:0] msig;          // significand, hidden bit at bit 52
    logic [5:0]  lz;
    logic [52:0] mnorm;
    logic signed [13:0] k;      // value = mnorm * 2^k (binary64 scale)
    logic signed [13:0] kg;
    logic        odd;
    logic signed [13:0] rexp_s;
    logic [63:0] sq_special;
    logic        sq_bypass;
    logic [5:0]  mb;

    // Leading zero count of the significand, as a priority scan.
    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i <= 52; i++)
        begin
            if (msig[i])
            begin
                lz = 6'(52 - i);
            end
        end
    end

    always_comb
    begin
        x       = is_double ? operand_bits : {32'd0, operand_bits[31:0]};
        mb      = is_double ? 6'd52 : 6'd23;
        signbit = is_double ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        qbit    = is_double ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
        neg     = (x & signbit) != 64'd0;
        sgn     = x & signbit;
        e       = is_double ? x[62:52] : {3'd0, x[30:23]};
        emask   = is_double ? 11'h7FF : 11'h0FF;
        bias    = is_double ? 11'h3FF : 11'h07F;
        mant    = is_double ? x[51:0] : {29'd0, x[22:0]};
        one     = is_double ? 64'h3FF0_0000_0000_0000 : 64'h0000_0000_3F80_0000;

        // Rounding to an integral value.
        fcnt  = 12'({1'b0, bias} + 12'(mb) - {1'b0, e});
        fmask = (64'd1 << fcnt[5:0]) - 64'd1;
        frac  = x & fmask;
        base  = x & ~fmask;
        half  = 64'd1 << (fcnt[5:0] - 6'd1);
        fstep = 64'd1 << fcnt[5:0];
        case (mode)
            fursq_pkg::MODE_CEIL:    inc = !neg;
            fursq_pkg::MODE_FLOOR:   inc = neg;
            fursq_pkg::MODE_NEAREST: inc = (frac > half) ||
                                           ((frac == half) && ((base & fstep) != 64'd0));
            default:                 inc = 1'b0;
        endcase
        if (e == emask)
        begin
            rnd = (mant != 52'd0) ? (x | qbit) : x;
        end
        else if ({1'b0, e} >= {1'b0, bias} + 12'(mb))
        begin
            rnd = x;
        end
        else if (e < bias)
        begin
            if (e == 11'd0 && mant == 52'd0)
            begin
                rnd = x;
            end
            else
            begin
                case (mode)
                    fursq_pkg::MODE_CEIL:    rnd = neg ? sgn : one;
                    fursq_pkg::MODE_FLOOR:   rnd = neg ? (sgn | one) : 64'd0;
                    fursq_pkg::MODE_NEAREST: rnd = (e == bias - 11'd1 && mant != 52'd0) ?
                                                   (sgn | one) : sgn;
                    default:                 rnd = sgn;
                endcase
            end
        end
        else if (frac == 64'd0)
        begin
            rnd = x;
        end
        else
        begin
            rnd = inc ? base + fstep : base;
        end

        // Square-root special cases.
        sq_bypass = 1'b1;
        if (e == emask && mant != 52'd0)
        begin
            sq_special = x | qbit;
        end
        else if (e == 11'd0 && mant == 52'd0)
        begin
            sq_special = x;
        end
        else if (neg)
        begin
            sq_special = is_double ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
        end
        else if (e == emask)
        begin
            sq_special = x;
        end
        else
        begin
            sq_special = 64'd0;
            sq_bypass  = 1'b0;
        end

        // Normalise to a 53-bit significand; binary32 is scaled up by 29 bits.
        msig = is_double ? {(e != 11'd0), x[51:0]} : {(e != 11'd0), x[22:0], 29'd0};
        mnorm = msig << lz;
        if (e == 11'd0)
        begin
            k = 14'sd1 - $signed({3'd0, bias}) - $signed({8'd0, mb}) - $signed({8'd0, lz});
        end
        else
        begin
            k = $signed({3'd0, e}) - $signed({3'd0, bias}) - $signed({8'd0, mb});
        end
        // Root of m*2^k with g = mb+2 (+1 when k-g odd): q has mb+2 bits.
        kg  = k - $signed({8'd0, mb}) - 14'sd2;
        odd = kg[0];
        rexp_s = ((kg - (odd ? 14'sd1 : 14'sd0)) >>> 1) + 14'sd1 + $signed({8'd0, mb})
                 + $signed({3'd0, bias});

        word_next        = '0;
        word_next.vld    = in_vld;
        word_next.dbl    = is_double;
        word_next.rexp   = rexp_s[11:0];
        word_next.bypass = (mode != fursq_pkg::MODE_SQRT) || sq_bypass;
        // Radicand m*2^g over 2*NCELL bits, with g = 54 or 55 on the binary64
        // scale, so that the root has 54 bits.
        word_next.rad = odd ? {mnorm, 55'd0} : {1'b0, mnorm, 54'd0};
        case (mode)
            fursq_pkg::MODE_ABS:     word_next.res = x & ~signbit;
            fursq_pkg::MODE_NEG:     word_next.res = x ^ signbit;
            fursq_pkg::MODE_CEIL,
            fursq_pkg::MODE_FLOOR,
            fursq_pkg::MODE_TRUNC,
            fursq_pkg::MODE_NEAREST: word_next.res = rnd;
            fursq_pkg::MODE_SQRT:    word_next.res = sq_special;
            default:                 word_next.res = x;
        endcase
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

[rtl/fursq_back.sv]
// ----------------------------------------------------------------------------
// fursq_back: root rounding and result packing
// Rounds the 54-bit root to nearest even, packs the result and holds it in
// the output register.
// ----------------------------------------------------------------------------
module fursq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  fursq_pkg::cell_word_t din,
    output logic                  out_vld,
    output logic [63:0]           out_res
);

    logic        vld_reg;
    logic [63:0] res_reg;
    logic [63:0] res_next;
    logic [53:0] q;
    logic [53:0] sig;
    logic [11:0] rexp;
    logic        rem_nz;
    logic        rbit;

    // For binary32 the root was taken on a significand scaled by 2^29, so its
    // top 25 bits hold the single-precision root and the rest adds to sticky.
    always_comb
    begin
        q      = din.q;
        rexp   = din.rexp;
        rem_nz = din.rem != '0;
        if (din.dbl)
        begin
            rbit = q[0];
            sig  = {1'b0, q[53:1]};
            if (rbit && (rem_nz || sig[0]))
            begin
                sig = sig + 54'd1;
            end
            if (sig[53])
            begin
                sig  = sig >> 1;
                rexp = rexp + 12'd1;
            end
            res_next = {1'b0, rexp[10:0], sig[51:0]};
        end
        else
        begin
            rbit   = q[29];
            rem_nz = rem_nz || (q[28:0] != 29'd0);
            sig    = {30'd0, q[53:30]};
            if (rbit && (rem_nz || sig[0]))
            begin
                sig = sig + 54'd1;
            end
            if (sig[24])
            begin
                sig  = sig >> 1;
                rexp = rexp + 12'd1;
            end
            res_next = {32'd0, 1'b0, rexp[7:0], sig[22:0]};
        end
        if (din.bypass)
        begin
            res_next = din.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_res = res_reg;

endmodule

[rtl/float_unary_round_sqrt_unit.sv]
// ----------------------------------------------------------------------------
// float_unary_round_sqrt_unit: IEEE-754 abs, neg, rounding and square root
// A front stage, a chain of square-root cells and a packing stage.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel s_axis takes one word per handshake: mode, is_double and
// the raw operand. The master channel m_axis returns one word per input with
// the raw result bits; binary32 results are zero-extended.
// Every operation travels the same pipeline: one front stage, 54 root cells
// (one root bit each) and one packing stage, whatever the mode, so results
// leave in input order.
// Throughput is one word per cycle; the pipeline advances whenever the output
// register is empty or being read.
// When the receiver stalls, the whole pipeline holds and s_axis_tready falls
// until m_axis_tready returns; no word is lost or repeated.
// Reset clears all valid flags; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module float_unary_round_sqrt_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // mode[2:0], is_double[3], operand_bits[67:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_bits[63:0]
);

    fursq_pkg::cell_word_t chain [fursq_pkg::NCELL+1];
    logic en;

    // The pipeline moves when the output slot is free or being taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fursq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (s_axis_tvalid),
        .mode         (s_axis_tdata[2:0]),
        .is_double    (s_axis_tdata[3]),
        .operand_bits (s_axis_tdata[67:4]),
        .dout         (chain[0])
    );

    // Root cells, one result bit each.
    for (genvar i = 0; i < fursq_pkg::NCELL; i++)
    begin : g_cell
        fursq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    fursq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .din     (chain[fursq_pkg::NCELL]),
        .out_vld (m_axis_tvalid),
        .out_res (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A stalled output must keep its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // Input is refused exactly while the output waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output slot");
    // A binary32 result has a clear upper half.
    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        chain[fursq_pkg::NCELL].vld && en && !chain[fursq_pkg::NCELL].dbl
        |=> m_axis_tdata[63:32] == 32'd0)
        else $error("binary32 result upper bits set");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for float_unary_round_sqrt_unit
// A directed table of corner operands, followed by random binary32 and
// binary64 words, is driven on s_axis with random gaps. Every returned word
// is compared against a bit-exact model of abs, neg, the rounding modes and
// the correctly rounded square root, while m_axis is stalled at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM = 400;
    localparam int N_TABLE  = 24;
    // Operation code with no operation assigned.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // mode[2:0], is_double[3], operand_bits[67:4]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // result_bits[63:0]

    // One directed row: operand, and the result where it is plain to see.
    typedef struct {
        logic [2:0]  mode;
        logic        dbl;
        logic [63:0] operand;
        logic        known;
        logic [63:0] result;
    } vector_t;

    logic [63:0] result_q[$];
    int          n_words;
    int          n_errors;
    int          n_mode[8];
    logic        calm;

    float_unary_round_sqrt_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Rounding to an integral value in the given format.
    function automatic logic [63:0] round_integral(logic [63:0] x, logic [2:0] mode,
                                                   int mb, int eb);
        logic [63:0] bias, emask, signbit, e, mant, one, sgn, fmask, frac, base, half;
        logic        neg, inc;
        int          f;
        bias    = (64'd1 << (eb - 1)) - 64'd1;
        emask   = (64'd1 << eb) - 64'd1;
        signbit = 64'd1 << (mb + eb);
        neg     = (x & signbit) != 0;
        e       = (x >> mb) & emask;
        mant    = x & ((64'd1 << mb) - 64'd1);
        one     = bias << mb;
        sgn     = x & signbit;
        if (e == emask)
            return (mant != 0) ? (x | (64'd1 << (mb - 1))) : x;
        if (e >= bias + mb)
            return x;
        if (e < bias)
        begin
            if (e == 0 && mant == 0)
                return x;
            case (mode)
                fursq_pkg::MODE_CEIL:    return neg ? sgn : one;
                fursq_pkg::MODE_FLOOR:   return neg ? (sgn | one) : 64'd0;
                fursq_pkg::MODE_NEAREST:
                    return (e == bias - 1 && mant != 0) ? (sgn | one) : sgn;
                default:                 return sgn;
            endcase
        end
        f     = int'(bias + mb - e);
        fmask = (64'd1 << f) - 64'd1;
        frac  = x & fmask;
        base  = x & ~fmask;
        inc   = 1'b0;
        if (frac == 0)
            return x;
        if (mode == fursq_pkg::MODE_CEIL)
            inc = !neg;
        else if (mode == fursq_pkg::MODE_FLOOR)
            inc = neg;
        else if (mode == fursq_pkg::MODE_NEAREST)
        begin
            half = 64'd1 << (f - 1);
            inc  = frac > half || (frac == half && ((base >> f) & 64'd1) != 0);
        end
        return inc ? base + (64'd1 << f) : base;
    endfunction

    // Square root rounded to nearest even, one root bit per step.
    function automatic logic [63:0] square_root(logic [63:0] x, int mb, int eb);
        logic [63:0] emask, signbit, e, m, hidden, q, rem, sig, pair, trial;
        int          bias, k, g, p, b1, b0, rexp;
        bias    = (1 << (eb - 1)) - 1;
        emask   = (64'd1 << eb) - 64'd1;
        signbit = 64'd1 << (mb + eb);
        e       = (x >> mb) & emask;
        m       = x & ((64'd1 << mb) - 64'd1);
        hidden  = 64'd1 << mb;
        q       = 64'd0;
        rem     = 64'd0;
        if (e == emask && m != 0)
            return x | (64'd1 << (mb - 1));
        if (e == 0 && m == 0)
            return x;
        if ((x & signbit) != 0)
            return (emask << mb) | (64'd1 << (mb - 1));
        if (e == emask)
            return x;
        if (e == 0)
        begin
            k = 1 - bias - mb;
            while ((m & hidden) == 0)
            begin
                m = m << 1;
                k--;
            end
        end
        else
        begin
            m = m | hidden;
            k = int'(e) - bias - mb;
        end
        // Make the exponent even so the root exponent is exact.
        g = mb + 2;
        if (((k - g) & 1) != 0)
            g++;
        for (p = mb + 1; p >= 0; p--)
        begin
            b1   = 2 * p + 1 - g;
            b0   = 2 * p - g;
            pair = 64'd0;
            if (b1 >= 0 && b1 < 64)
                pair = pair | (((m >> b1) & 64'd1) << 1);
            if (b0 >= 0 && b0 < 64)
                pair = pair | ((m >> b0) & 64'd1);
            rem   = (rem << 2) | pair;
            trial = (q << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                q   = (q << 1) | 64'd1;
            end
            else
                q = q << 1;
        end
        sig  = q >> 1;
        rexp = (k - g) / 2 + 1 + mb + bias;
        if (q[0] && (rem != 0 || sig[0]))
            sig++;
        if ((sig >> (mb + 1)) != 0)
        begin
            sig = sig >> 1;
            rexp++;
        end
        return (64'(rexp) << mb) | (sig & (hidden - 64'd1));
    endfunction

    // Expected result word for one operation.
    function automatic logic [63:0] unary_result(logic [2:0] mode, logic dbl,
                                                 logic [63:0] operand);
        logic [63:0] wmask, x, signbit, r;
        int          mb, eb;
        mb      = dbl ? 52 : 23;
        eb      = dbl ? 11 : 8;
        wmask   = dbl ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        x       = operand & wmask;
        signbit = 64'd1 << (mb + eb);
        case (mode)
            fursq_pkg::MODE_ABS:     r = x & ~signbit;
            fursq_pkg::MODE_NEG:     r = x ^ signbit;
            fursq_pkg::MODE_CEIL, fursq_pkg::MODE_FLOOR,
            fursq_pkg::MODE_TRUNC, fursq_pkg::MODE_NEAREST:
                                     r = round_integral(x, mode, mb, eb);
            fursq_pkg::MODE_SQRT:    r = square_root(x, mb, eb);
            default:                 r = x;
        endcase
        return r & wmask;
    endfunction

    // Random operand, biased towards exponents where rounding is interesting.
    function automatic logic [63:0] random_operand(logic dbl);
        logic [63:0] x, mant;
        int          mb, eb, bias, e;
        mb   = dbl ? 52 : 23;
        eb   = dbl ? 11 : 8;
        bias = (1 << (eb - 1)) - 1;
        mant = {$urandom, $urandom} & ((64'd1 << mb) - 64'd1);
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1:       e = 0;
            2:       e = (1 << eb) - 1;
            3:       e = $urandom_range(1, (1 << eb) - 2);
            4:       begin
                         e    = $urandom_range(bias - 1, bias + mb);
                         mant = mant & ~((64'd1 << $urandom_range(0, mb)) - 64'd1);
                     end
            5:       begin
                         e    = $urandom_range(bias, bias + mb);
                         mant = mant & ~((64'd1 << $urandom_range(0, mb)) - 64'd1);
                         mant = mant | (64'd1 << $urandom_range(0, mb - 1));
                     end
            default: e = $urandom_range(bias - 3, bias + mb + 2);
        endcase
        x = (64'($urandom_range(0, 1)) << (mb + eb)) | (64'(e) << mb) | mant;
        // Junk in the unused upper half of a binary32 operand.
        if (!dbl)
            x[63:32] = $urandom;
        return x;
    endfunction

    // Present one word and wait for its handshake.
    task automatic send_word(logic [2:0] mode, logic dbl, logic [63:0] operand);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, operand, dbl, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        result_q.push_back(unary_result(mode, dbl, operand));
        n_mode[mode]++;
    endtask

    // Stimulus.
    initial
    begin : stimulus
        vector_t vectors[N_TABLE];
        logic    dbl;
        vectors = '{
            '{fursq_pkg::MODE_ABS,     1'b0, 64'hBF80_0000, 1'b1, 64'h3F80_0000},
            '{fursq_pkg::MODE_ABS,     1'b1, 64'hFFF0_0000_0000_0001, 1'b1,
              64'h7FF0_0000_0000_0001},
            '{fursq_pkg::MODE_NEG,     1'b1, 64'h0, 1'b1, 64'h8000_0000_0000_0000},
            '{fursq_pkg::MODE_NEG,     1'b0, 64'hFFFF_FFFF_7FC0_0001, 1'b1, 64'hFFC0_0001},
            '{fursq_pkg::MODE_CEIL,    1'b0, 64'h3F00_0000, 1'b1, 64'h3F80_0000},
            '{fursq_pkg::MODE_CEIL,    1'b0, 64'h0000_0001, 1'b1, 64'h3F80_0000},
            '{fursq_pkg::MODE_CEIL,    1'b0, 64'hDEAD_BEEF_3F80_0000, 1'b1, 64'h3F80_0000},
            '{fursq_pkg::MODE_FLOOR,   1'b0, 64'hBF00_0000, 1'b1, 64'hBF80_0000},
            '{fursq_pkg::MODE_FLOOR,   1'b1, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1,
              64'h7FEF_FFFF_FFFF_FFFF},
            '{fursq_pkg::MODE_TRUNC,   1'b1, 64'hBFE0_0000_0000_0000, 1'b1,
              64'h8000_0000_0000_0000},
            '{fursq_pkg::MODE_TRUNC,   1'b0, 64'h7F80_0001, 1'b1, 64'h7FC0_0001},
            '{fursq_pkg::MODE_NEAREST, 1'b0, 64'h3FC0_0000, 1'b1, 64'h4000_0000},
            '{fursq_pkg::MODE_NEAREST, 1'b0, 64'h4020_0000, 1'b1, 64'h4000_0000},
            '{fursq_pkg::MODE_NEAREST, 1'b0, 64'h3F00_0000, 1'b1, 64'h0},
            '{fursq_pkg::MODE_NEAREST, 1'b0, 64'hBF00_0001, 1'b1, 64'hBF80_0000},
            '{fursq_pkg::MODE_SQRT,    1'b0, 64'h4080_0000, 1'b1, 64'h4000_0000},
            '{fursq_pkg::MODE_SQRT,    1'b0, 64'hBF80_0000, 1'b1, 64'h7FC0_0000},
            '{fursq_pkg::MODE_SQRT,    1'b1, 64'hFFF0_0000_0000_0000, 1'b1,
              64'h7FF8_0000_0000_0000},
            '{fursq_pkg::MODE_SQRT,    1'b0, 64'h7F80_0000, 1'b1, 64'h7F80_0000},
            '{fursq_pkg::MODE_SQRT,    1'b1, 64'h8000_0000_0000_0000, 1'b1,
              64'h8000_0000_0000_0000},
            '{fursq_pkg::MODE_SQRT,    1'b1, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
            '{fursq_pkg::MODE_SQRT,    1'b0, 64'h007F_FFFF, 1'b0, 64'h0},
            '{fursq_pkg::MODE_SQRT,    1'b1, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
            '{MODE_UNUSED,             1'b0, 64'hFFFF_FFFF_1234_5678, 1'b1, 64'h1234_5678}
        };
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        n_words       = 0;
        n_errors      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: hand-typed results must also agree with the model.
        foreach (vectors[i])
        begin
            if (vectors[i].known && unary_result(vectors[i].mode, vectors[i].dbl,
                                                 vectors[i].operand) != vectors[i].result)
            begin
                $display("table row %0d: typed result %h disagrees with model", i,
                         vectors[i].result);
                n_errors++;
            end
            send_word(vectors[i].mode, vectors[i].dbl, vectors[i].operand);
        end

        // Random words, with a burst of fifty free of gaps and stalls in every two hundred.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = ((i / 50) % 4) == 3;
            dbl  = $urandom_range(0, 1);
            send_word(($urandom_range(0, 15) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6)),
                      dbl, random_operand(dbl));
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait (result_q.size() == 0);
        repeat (60) @(posedge clk);
        if (result_q.size() != 0)
            n_errors++;
        $display("Checked %0d result words: abs %0d, neg %0d, ceil %0d, floor %0d,",
                 n_words, n_mode[0], n_mode[1], n_mode[2], n_mode[3]);
        $display("trunc %0d, nearest %0d, sqrt %0d, unused code %0d; %0d mismatches.",
                 n_mode[4], n_mode[5], n_mode[6], n_mode[7], n_errors);
        if (n_errors == 0)
            $display("float_unary_round_sqrt_unit verification clean");
        else
            $display("float_unary_round_sqrt_unit verification failed");
        $finish;
    end

    // Receiver with random stalls.
    initial
    begin : receiver
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_words++;
            if (result_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word %h", m_axis_tdata);
            end
            else if (m_axis_tdata !== result_q[0])
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result_bits mismatch: expected %h, got %h",
                             result_q[0], m_axis_tdata);
                void'(result_q.pop_front());
            end
            else
                void'(result_q.pop_front());
        end
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", result_q.size());
        $display("float_unary_round_sqrt_unit verification failed");
        $finish;
    end

endmodule
